[rtl/assert_macros.svh]
// assertion helpers included by cell_list_neighbour_search_top
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// property must hold at every rising clock edge outside reset
`define CLS_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);
// expression must never be true outside reset
`define CLS_ASSERT_NEVER(lbl, clk, rstn, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(expr)) else $error(msg);
`else
`define CLS_ASSERT(lbl, clk, rstn, prop, msg)
`define CLS_ASSERT_NEVER(lbl, clk, rstn, expr, msg)
`endif
`endif

[rtl/cls_pkg.sv]
package cls_pkg;

  // operation codes
  typedef enum logic [1:0] {
    OP_CLEAR  = 2'd0,
    OP_LOAD   = 2'd1,
    OP_QUERY  = 2'd2,
    OP_UNUSED = 2'd3
  } op_e;

  // result status codes
  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_FULL    = 2'd1,
    ST_OUTSIDE = 2'd2
  } status_e;

  // configuration register indexes
  typedef enum logic [2:0] {
    CFG_CELL_X = 3'd0,
    CFG_CELL_Y = 3'd1,
    CFG_CELL_Z = 3'd2,
    CFG_ORG_X  = 3'd3,
    CFG_ORG_Y  = 3'd4,
    CFG_ORG_Z  = 3'd5
  } cfg_idx_e;

  localparam int unsigned PosW   = 16;
  localparam int unsigned CsW    = 7;
  localparam int unsigned SlotW  = 6;
  localparam int unsigned CountW = 7;
  localparam int unsigned ExclW  = 7;
  localparam int unsigned CfgW   = 16;
  localparam logic [SlotW-1:0] MaxNbr = 6'd63;

endpackage

[rtl/cls_ram.sv]
module cls_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                                      clk_i,
  input  logic                                      we_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  logic [Width-1:0]                          wdata_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic [Width-1:0]                          rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

[rtl/cls_bin.sv]
module cls_bin #(
  parameter int unsigned Grid = 4,
  parameter int unsigned GMax = 4
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            go_i,
  input  logic signed [cls_pkg::PosW-1:0] pos_i,
  input  logic signed [cls_pkg::PosW-1:0] org_i,
  input  logic [cls_pkg::CsW-1:0]         cs_i,
  output logic                            done_o,
  output logic                            outside_o,
  output logic [$clog2(GMax+1)-1:0]       idx_o
);

  localparam int unsigned IdxW = $clog2(GMax + 1);
  localparam int unsigned AccW = 17 + IdxW;

  logic signed [16:0] p_q;
  logic [AccW-1:0]    acc_q, d_q;
  logic [IdxW-1:0]    idx_q, cnt_q;
  logic               run_q;

  // count the cell boundaries below p, one boundary per cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q <= 1'b0;
      cnt_q <= '0;
      idx_q <= '0;
    end else if (go_i) begin
      run_q <= 1'b1;
      cnt_q <= '0;
      idx_q <= '0;
    end else if (run_q) begin
      if (cnt_q == IdxW'(GMax)) begin
        run_q <= 1'b0;
      end else begin
        cnt_q <= cnt_q + 1'b1;
        if (!p_q[16] && (AccW'(p_q[15:0]) > acc_q)) begin
          idx_q <= idx_q + 1'b1;
        end
      end
    end
  end

  // payload: offset position and running boundary
  always_ff @(posedge clk_i) begin
    if (go_i) begin
      p_q   <= $signed({pos_i[15], pos_i}) - $signed({org_i[15], org_i});
      d_q   <= (cs_i == '0) ? AccW'(256) : AccW'({cs_i, 8'd0});
      acc_q <= (cs_i == '0) ? AccW'(256) : AccW'({cs_i, 8'd0});
    end else if (run_q) begin
      acc_q <= acc_q + d_q;
    end
  end

  assign done_o    = run_q && (cnt_q == IdxW'(GMax));
  assign outside_o = p_q[16] || (idx_q >= IdxW'(Grid));
  assign idx_o     = idx_q;

endmodule

[rtl/cell_list_neighbour_search_top.sv]
// channel  | direction | handshake              | payload
// cfg      | in        | cfg_we_i               | cfg_idx_i, cfg_data_i
// command  | in        | start high, busy low   | operation_i, pos_*_i, exclude_id_i
// result   | out       | res_valid_o, one cycle | status_o .. last_o
// clear answers in the cycle after accept; load answers once the serial binning units finish.
// query: binning, then a step in S_OFFS for each of the 27 offsets, one store
// read per stored slot for each offset inside the grid, a drain, then the count.
// reset clears control state and stored count; store contents are not cleared.
// results cannot be stalled: each is shown for exactly one cycle.
`include "assert_macros.svh"

module cell_list_neighbour_search_top #(
  parameter int unsigned MAX_PARTICLES = 64,
  parameter int unsigned GRID_X = 4,
  parameter int unsigned GRID_Y = 4,
  parameter int unsigned GRID_Z = 4
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   cfg_we_i,
  input  logic [2:0]                             cfg_idx_i,
  input  logic [cls_pkg::CfgW-1:0]               cfg_data_i,
  input  logic                                   start,
  output logic                                   busy,
  input  logic [1:0]                             operation_i,
  input  logic signed [cls_pkg::PosW-1:0]        pos_x_i,
  input  logic signed [cls_pkg::PosW-1:0]        pos_y_i,
  input  logic signed [cls_pkg::PosW-1:0]        pos_z_i,
  input  logic [cls_pkg::ExclW-1:0]              exclude_id_i,
  output logic                                   res_valid_o,
  output logic [1:0]                             status_o,
  output logic [cls_pkg::SlotW-1:0]              slot_id_o,
  output logic signed [cls_pkg::PosW-1:0]        nbr_x_o,
  output logic signed [cls_pkg::PosW-1:0]        nbr_y_o,
  output logic signed [cls_pkg::PosW-1:0]        nbr_z_o,
  output logic [cls_pkg::SlotW-1:0]              nbr_count_o,
  output logic                                   last_o
);

  localparam int unsigned GMaxXY = (GRID_X > GRID_Y) ? GRID_X : GRID_Y;
  localparam int unsigned GMax   = (GMaxXY > GRID_Z) ? GMaxXY : GRID_Z;
  localparam int unsigned IdxW   = $clog2(GMax + 1);
  localparam int unsigned NCells = GRID_X * GRID_Y * GRID_Z;
  localparam int unsigned CellW  = (NCells > 1) ? $clog2(NCells) : 1;
  localparam int unsigned AddrW  = (MAX_PARTICLES > 1) ? $clog2(MAX_PARTICLES) : 1;
  localparam int unsigned DataW  = 3 * cls_pkg::PosW + CellW;
  localparam int unsigned CntW   = cls_pkg::CountW;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_BIN   = 5'b00010,
    S_OFFS  = 5'b00100,
    S_SCAN  = 5'b01000,
    S_DRAIN = 5'b10000
  } state_e;

  state_e state_q, state_d;

  // configuration registers
  logic [cls_pkg::CsW-1:0]         csx_q, csy_q, csz_q;
  logic signed [cls_pkg::PosW-1:0] orgx_q, orgy_q, orgz_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      csx_q  <= 7'd1;
      csy_q  <= 7'd1;
      csz_q  <= 7'd1;
      orgx_q <= '0;
      orgy_q <= '0;
      orgz_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        cls_pkg::CFG_CELL_X: csx_q  <= cfg_data_i[cls_pkg::CsW-1:0];
        cls_pkg::CFG_CELL_Y: csy_q  <= cfg_data_i[cls_pkg::CsW-1:0];
        cls_pkg::CFG_CELL_Z: csz_q  <= cfg_data_i[cls_pkg::CsW-1:0];
        cls_pkg::CFG_ORG_X:  orgx_q <= cfg_data_i;
        cls_pkg::CFG_ORG_Y:  orgy_q <= cfg_data_i;
        cls_pkg::CFG_ORG_Z:  orgz_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // command latch
  logic accept;
  logic [1:0] op_q;
  logic signed [cls_pkg::PosW-1:0] qx_q, qy_q, qz_q;
  logic [cls_pkg::ExclW-1:0] excl_q;

  assign accept = start && !busy;

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q   <= operation_i;
      qx_q   <= pos_x_i;
      qy_q   <= pos_y_i;
      qz_q   <= pos_z_i;
      excl_q <= exclude_id_i;
    end
  end

  // binning units, one per axis
  logic bin_go;
  logic donex, doney, donez, outx, outy, outz;
  logic [IdxW-1:0] cx, cy, cz;

  assign bin_go = accept && ((operation_i == cls_pkg::OP_LOAD) ||
                             (operation_i == cls_pkg::OP_QUERY));

  cls_bin #(.Grid(GRID_X), .GMax(GMax)) u_bin_x (
    .clk_i, .rst_ni, .go_i(bin_go), .pos_i(pos_x_i), .org_i(orgx_q), .cs_i(csx_q),
    .done_o(donex), .outside_o(outx), .idx_o(cx)
  );
  cls_bin #(.Grid(GRID_Y), .GMax(GMax)) u_bin_y (
    .clk_i, .rst_ni, .go_i(bin_go), .pos_i(pos_y_i), .org_i(orgy_q), .cs_i(csy_q),
    .done_o(doney), .outside_o(outy), .idx_o(cy)
  );
  cls_bin #(.Grid(GRID_Z), .GMax(GMax)) u_bin_z (
    .clk_i, .rst_ni, .go_i(bin_go), .pos_i(pos_z_i), .org_i(orgz_q), .cs_i(csz_q),
    .done_o(donez), .outside_o(outz), .idx_o(cz)
  );

  // particle store
  logic             ram_we;
  logic [AddrW-1:0] ram_waddr, ram_raddr;
  logic [DataW-1:0] ram_wdata, ram_rdata;
  logic [CellW-1:0] home_cell;

  assign home_cell = CellW'(32'(cx) * GRID_Y * GRID_Z + 32'(cy) * GRID_Z + 32'(cz));

  cls_ram #(.Width(DataW), .Depth(MAX_PARTICLES)) u_store (
    .clk_i, .we_i(ram_we), .waddr_i(ram_waddr), .wdata_i(ram_wdata),
    .raddr_i(ram_raddr), .rdata_o(ram_rdata)
  );

  // neighbour cell for the current offset
  logic [1:0] ox_q, oy_q, oz_q;
  logic [IdxW:0] tx, ty, tz;
  logic nvalid, last_off;
  logic [IdxW-1:0] nx, ny, nz;
  logic [CellW-1:0] nbr_cell;

  assign tx = {1'b0, cx} + (IdxW+1)'(ox_q);
  assign ty = {1'b0, cy} + (IdxW+1)'(oy_q);
  assign tz = {1'b0, cz} + (IdxW+1)'(oz_q);
  assign nx = IdxW'(tx - 1'b1);
  assign ny = IdxW'(ty - 1'b1);
  assign nz = IdxW'(tz - 1'b1);
  assign nvalid = (tx != '0) && (tx <= (IdxW+1)'(GRID_X)) &&
                  (ty != '0) && (ty <= (IdxW+1)'(GRID_Y)) &&
                  (tz != '0) && (tz <= (IdxW+1)'(GRID_Z));
  assign nbr_cell = CellW'(32'(nx) * GRID_Y * GRID_Z + 32'(ny) * GRID_Z + 32'(nz));
  assign last_off = (ox_q == 2'd2) && (oy_q == 2'd2) && (oz_q == 2'd2);

  // control registers
  logic [CntW-1:0]  count_q, count_d, s_q, s_d;
  logic [CellW-1:0] cell_q, cell_d;
  logic [1:0]       ox_d, oy_d, oz_d;
  logic [29:0]      r2_q, r2_d;
  logic [13:0]      csq;
  logic [cls_pkg::CsW-1:0] cs_eff;
  logic             rd_vld_q, rd_vld_d;
  logic [CntW-1:0]  rd_slot_q;
  logic [CellW-1:0] rd_cell_q;
  logic [cls_pkg::SlotW-1:0] n_q, n_d;

  assign cs_eff = (csx_q == '0) ? 7'd1 : csx_q;
  assign csq    = 14'(cs_eff * cs_eff);

  // pipeline stage 1: cell match, exclusion and squares
  logic signed [16:0] dx, dy, dz;
  logic signed [33:0] mx, my, mz;
  logic               hit1;
  logic               p1_vld_q;
  logic [CntW-1:0]    p1_slot_q;
  logic [47:0]        p1_pos_q;
  logic [31:0]        sqx_q, sqy_q, sqz_q;

  assign dx = $signed({ram_rdata[15], ram_rdata[15:0]}) - $signed({qx_q[15], qx_q});
  assign dy = $signed({ram_rdata[31], ram_rdata[31:16]}) - $signed({qy_q[15], qy_q});
  assign dz = $signed({ram_rdata[47], ram_rdata[47:32]}) - $signed({qz_q[15], qz_q});
  assign mx = dx * dx;
  assign my = dy * dy;
  assign mz = dz * dz;
  assign hit1 = rd_vld_q && (ram_rdata[DataW-1:48] == rd_cell_q) &&
                (rd_slot_q != excl_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p1_vld_q <= 1'b0;
    end else begin
      p1_vld_q <= hit1;
    end
  end

  always_ff @(posedge clk_i) begin
    p1_slot_q <= rd_slot_q;
    p1_pos_q  <= ram_rdata[47:0];
    sqx_q     <= mx[31:0];
    sqy_q     <= my[31:0];
    sqz_q     <= mz[31:0];
  end

  // pipeline stage 2: radius compare
  logic [33:0] dist2;
  logic        emit_nbr;

  assign dist2    = 34'(sqx_q) + 34'(sqy_q) + 34'(sqz_q);
  assign emit_nbr = p1_vld_q && (dist2 <= 34'(r2_q)) && (n_q != cls_pkg::MaxNbr);

  // result register next values
  logic        rv_d;
  logic [1:0]  rst_d;
  logic [cls_pkg::SlotW-1:0] rslot_d, rcnt_d;
  logic [47:0] rpos_d;
  logic        rlast_d;

  // sequencer
  always_comb begin
    state_d   = state_q;
    count_d   = count_q;
    s_d       = s_q;
    cell_d    = cell_q;
    ox_d      = ox_q;
    oy_d      = oy_q;
    oz_d      = oz_q;
    r2_d      = r2_q;
    n_d       = n_q;
    rd_vld_d  = 1'b0;
    ram_we    = 1'b0;
    ram_waddr = count_q[AddrW-1:0];
    ram_wdata = {home_cell, qz_q, qy_q, qx_q};
    ram_raddr = s_q[AddrW-1:0];
    rv_d      = 1'b0;
    rst_d     = cls_pkg::ST_OK;
    rslot_d   = '0;
    rcnt_d    = '0;
    rpos_d    = '0;
    rlast_d   = 1'b0;

    if (emit_nbr) begin
      rv_d    = 1'b1;
      rslot_d = p1_slot_q[cls_pkg::SlotW-1:0];
      rpos_d  = p1_pos_q;
      n_d     = n_q + 1'b1;
    end

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          if (operation_i == cls_pkg::OP_CLEAR) begin
            count_d = '0;
            rv_d    = 1'b1;
            rlast_d = 1'b1;
          end else if (bin_go) begin
            state_d = S_BIN;
          end
        end
      end
      S_BIN: begin
        if (donex && doney && donez) begin
          priority if (outx || outy || outz) begin
            rv_d    = 1'b1;
            rst_d   = cls_pkg::ST_OUTSIDE;
            rlast_d = 1'b1;
            state_d = S_IDLE;
          end else if (op_q == cls_pkg::OP_LOAD) begin
            rv_d    = 1'b1;
            rlast_d = 1'b1;
            state_d = S_IDLE;
            if (count_q >= CntW'(MAX_PARTICLES)) begin
              rst_d = cls_pkg::ST_FULL;
            end else begin
              ram_we  = 1'b1;
              rslot_d = count_q[cls_pkg::SlotW-1:0];
              count_d = count_q + 1'b1;
            end
          end else begin
            r2_d    = {csq, 16'd0};
            n_d     = '0;
            ox_d    = '0;
            oy_d    = '0;
            oz_d    = '0;
            state_d = S_OFFS;
          end
        end
      end
      S_OFFS: begin
        if (nvalid && (count_q != '0)) begin
          cell_d  = nbr_cell;
          s_d     = '0;
          state_d = S_SCAN;
        end else if (last_off) begin
          state_d = S_DRAIN;
        end else begin
          oz_d = (oz_q == 2'd2) ? 2'd0 : oz_q + 1'b1;
          if (oz_q == 2'd2) begin
            oy_d = (oy_q == 2'd2) ? 2'd0 : oy_q + 1'b1;
            if (oy_q == 2'd2) begin
              ox_d = ox_q + 1'b1;
            end
          end
        end
      end
      S_SCAN: begin
        rd_vld_d = 1'b1;
        s_d      = s_q + 1'b1;
        if (s_q == count_q - 1'b1) begin
          if (last_off) begin
            state_d = S_DRAIN;
          end else begin
            state_d = S_OFFS;
            oz_d = (oz_q == 2'd2) ? 2'd0 : oz_q + 1'b1;
            if (oz_q == 2'd2) begin
              oy_d = (oy_q == 2'd2) ? 2'd0 : oy_q + 1'b1;
              if (oy_q == 2'd2) begin
                ox_d = ox_q + 1'b1;
              end
            end
          end
        end
      end
      S_DRAIN: begin
        if (!rd_vld_q && !p1_vld_q) begin
          rv_d    = 1'b1;
          rcnt_d  = n_q;
          rlast_d = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      rd_vld_q    <= 1'b0;
      res_valid_o <= 1'b0;
      n_q         <= '0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      rd_vld_q    <= rd_vld_d;
      res_valid_o <= rv_d;
      n_q         <= n_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    s_q         <= s_d;
    cell_q      <= cell_d;
    ox_q        <= ox_d;
    oy_q        <= oy_d;
    oz_q        <= oz_d;
    r2_q        <= r2_d;
    rd_slot_q   <= s_q;
    rd_cell_q   <= cell_q;
    status_o    <= rst_d;
    slot_id_o   <= rslot_d;
    nbr_x_o     <= rpos_d[15:0];
    nbr_y_o     <= rpos_d[31:16];
    nbr_z_o     <= rpos_d[47:32];
    nbr_count_o <= rcnt_d;
    last_o      <= rlast_d;
  end

  assign busy = (state_q != S_IDLE);

  // checks
  `CLS_ASSERT_NEVER(a_count_max, clk_i, rst_ni, count_q > CntW'(MAX_PARTICLES),
                    "stored count beyond capacity")
  `CLS_ASSERT(a_we_bin, clk_i, rst_ni, ram_we |-> (state_q == S_BIN),
              "store written outside binning")
  `CLS_ASSERT(a_rd_scan, clk_i, rst_ni, rd_vld_q |-> $past(state_q == S_SCAN),
              "store read outside scan")
  `CLS_ASSERT(a_idle_empty, clk_i, rst_ni, !busy |-> (!rd_vld_q && !p1_vld_q),
              "pipeline busy while idle")

endmodule
